### hdl/snapshot_interp_extrapolator_top_defines.svh
// assertion macros used by the checker file
// no dependencies
`ifndef SNAPSHOT_INTERP_EXTRAPOLATOR_TOP_DEFINES_SVH
`define SNAPSHOT_INTERP_EXTRAPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snapshot extrapolator check failed");

// next-cycle implication, disabled while reset is low
`define SIE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snapshot extrapolator check failed");

`endif

### hdl/sie_pkg.sv
// shared types, constants and helpers for the snapshot extrapolator
// no dependencies
package sie_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int W          = 32;
    localparam int DELAY_W    = 17;
    localparam int LIMIT_W    = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_AXES   = 3;
    localparam int AX_W       = 2;
    localparam int MUL_A_W    = W + 1;
    localparam int MUL_B_W    = LIMIT_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ITER_W     = $clog2(FRAC_BITS + 1);
    localparam int SUM_W      = PROD_W - FRAC_BITS + 1;

    localparam logic [DELAY_W-1:0] RENDER_DELAY_RESET = 17'd6554;
    localparam logic [LIMIT_W-1:0] EXTRAP_LIMIT_RESET = 19'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_RENDER_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP_LIMIT = 2'd1;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OC_NONE   = 2'd0,
        OC_INTERP = 2'd1,
        OC_EXTRAP = 2'd2
    } t_outcome;

    typedef struct packed {
        logic        [W-1:0] t;
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic signed [W-1:0] pz;
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
        logic signed [W-1:0] vz;
    } t_snap;

    typedef struct packed {
        logic                      vld;
        logic [AX_W-1:0]           idx;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        logic signed [W-1:0]       base;
    } t_mac_req;

    typedef struct packed {
        logic                vld;
        logic [AX_W-1:0]     idx;
        logic signed [W-1:0] value;
    } t_mac_rsp;

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(RING_DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

### hdl/sie_ring.sv
// snapshot ring storage, one write port and one registered read port
// depends on sie_pkg
module sie_ring (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [sie_pkg::IDX_W-1:0]  i_wr_addr,
    input  sie_pkg::t_snap             i_wr_data,
    input  logic [sie_pkg::IDX_W-1:0]  i_rd_addr,
    output sie_pkg::t_snap             o_rd_data
);
    import sie_pkg::*;

    t_snap r_mem [RING_DEPTH];
    t_snap r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/sie_div.sv
// restoring divider producing the q0.16 interpolation fraction, one bit per cycle
// depends on sie_pkg
module sie_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sie_pkg::W-1:0]         i_num,
    input  logic [sie_pkg::W-1:0]         i_den,
    output logic                          o_done,
    output logic [sie_pkg::FRAC_BITS-1:0] o_quo
);
    import sie_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [ITER_W-1:0]    r_cnt, n_cnt;
    logic [W-1:0]         r_rem, n_rem;
    logic [W-1:0]         r_den, n_den;
    logic [FRAC_BITS-1:0] r_quo, n_quo;
    logic [W:0]           shifted;
    logic [W:0]           diff;
    logic                 ge;

    assign shifted = {r_rem, 1'b0};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_den  = i_den;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = ge ? diff[W-1:0] : shifted[W-1:0];
            n_quo = {r_quo[FRAC_BITS-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ITER_W'(FRAC_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hdl/sie_mac.sv
// shared multiply, floor shift, add and saturate unit, two register stages
// depends on sie_pkg
module sie_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sie_pkg::t_mac_req i_req,
    output sie_pkg::t_mac_rsp o_rsp
);
    import sie_pkg::*;

    logic                     r_vld1, r_vld2;
    logic [AX_W-1:0]          r_idx1, r_idx2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [W-1:0]      r_base;
    logic signed [W-1:0]      r_value, n_value;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-W:0]         upper;

    assign sum   = {{(SUM_W - W){r_base[W-1]}}, r_base}
                 + {r_prod[PROD_W-1], r_prod[PROD_W-1:FRAC_BITS]};
    assign upper = sum[SUM_W-1:W-1];

    always_comb begin
        if (!sum[SUM_W-1] && (|upper)) begin
            n_value = {1'b0, {(W - 1){1'b1}}};
        end else if (sum[SUM_W-1] && !(&upper)) begin
            n_value = {1'b1, {(W - 1){1'b0}}};
        end else begin
            n_value = sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_req.vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        r_base  <= i_req.base;
        r_idx1  <= i_req.idx;
        r_idx2  <= r_idx1;
        r_value <= n_value;
    end

    assign o_rsp.vld   = r_vld2;
    assign o_rsp.idx   = r_idx2;
    assign o_rsp.value = r_value;

endmodule

### hdl/snapshot_interp_extrapolator_top.sv
// Snapshot interpolator and dead-reckoning extrapolator. A push is written to the ring and
// the block stays ready. A query with an empty ring or a negative render time goes straight
// to the done state; otherwise the sequencer reads the ring newest first, one entry per
// cycle through the registered read port, until it finds a snapshot at or before the render
// time or has read every filled entry without a match. Interpolation then runs the restoring
// divider, and both paths send the three axes through the shared two-stage multiply unit and
// then load the output register, which a held result blocks until it is taken. Depends on
// sie_pkg, sie_ring, sie_div and sie_mac.
module snapshot_interp_extrapolator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sie_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sie_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cmd,
    input  logic [31:0]                    i_snap_time,
    input  logic signed [31:0]             i_pos_x,
    input  logic signed [31:0]             i_pos_y,
    input  logic signed [31:0]             i_pos_z,
    input  logic signed [31:0]             i_vel_x,
    input  logic signed [31:0]             i_vel_y,
    input  logic signed [31:0]             i_vel_z,
    input  logic [31:0]                    i_query_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_outcome,
    output logic signed [31:0]             o_out_x,
    output logic signed [31:0]             o_out_y,
    output logic signed [31:0]             o_out_z
);
    import sie_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DIV   = 6'b001000,
        S_MAC   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [DELAY_W-1:0]   r_delay;
    logic [LIMIT_W-1:0]   r_limit;
    logic [IDX_W-1:0]     r_head;
    logic [CNT_W-1:0]     r_fill;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [W-1:0]         r_render, n_render;
    t_snap                r_older, n_older;
    t_snap                r_newer, n_newer;
    t_outcome             r_oc, n_oc;
    logic [FRAC_BITS-1:0] r_frac, n_frac;
    logic [LIMIT_W-1:0]   r_dt, n_dt;
    logic [AX_W-1:0]      r_ax, n_ax;
    logic signed [W-1:0]  r_res [NUM_AXES];
    logic                 res_clear;
    logic                 r_out_vld;
    logic [1:0]           r_out_oc;
    logic signed [W-1:0]  r_out_x, r_out_y, r_out_z;

    logic                 in_acc;
    logic                 push_acc;
    logic [W:0]           render_ext;
    logic [IDX_W-1:0]     rd_addr;
    t_snap                rd_data;
    t_snap                wr_data;
    logic                 hit;
    logic [W-1:0]         elapsed;
    logic                 div_start;
    logic                 div_done;
    logic [FRAC_BITS-1:0] div_quo;
    t_mac_req             mac_req;
    t_mac_rsp             mac_rsp;
    logic signed [W-1:0]  sel_new, sel_old, sel_vel;
    logic                 out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign push_acc   = in_acc && (i_cmd == CMD_PUSH);
    assign render_ext = {1'b0, i_query_time} - {{(W + 1 - DELAY_W){1'b0}}, r_delay};
    assign hit        = rd_data.t <= r_render;
    assign elapsed    = r_render - rd_data.t;
    assign out_load   = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    assign wr_data = '{t: i_snap_time, px: i_pos_x, py: i_pos_y, pz: i_pos_z,
                       vx: i_vel_x, vy: i_vel_y, vz: i_vel_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= RENDER_DELAY_RESET;
            r_limit <= EXTRAP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RENDER_DELAY: r_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_EXTRAP_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (push_acc) begin
            r_head <= idx_inc(r_head);
            if (r_fill != CNT_W'(RING_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    sie_ring u_ring (
        .i_clk     (i_clk),
        .i_we      (push_acc),
        .i_wr_addr (r_head),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (elapsed),
        .i_den   (r_newer.t - rd_data.t),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        unique case (r_ax)
            AX_W'(0): begin
                sel_new = r_newer.px;
                sel_old = r_older.px;
                sel_vel = r_older.vx;
            end
            AX_W'(1): begin
                sel_new = r_newer.py;
                sel_old = r_older.py;
                sel_vel = r_older.vy;
            end
            default: begin
                sel_new = r_newer.pz;
                sel_old = r_older.pz;
                sel_vel = r_older.vz;
            end
        endcase
    end

    always_comb begin
        mac_req.vld  = (r_state == S_MAC) && (r_ax != AX_W'(NUM_AXES));
        mac_req.idx  = r_ax;
        mac_req.base = sel_old;
        if (r_oc == OC_INTERP) begin
            mac_req.a = {sel_new[W-1], sel_new} - {sel_old[W-1], sel_old};
            mac_req.b = {{(MUL_B_W - FRAC_BITS){1'b0}}, r_frac};
        end else begin
            mac_req.a = {sel_vel[W-1], sel_vel};
            mac_req.b = {{(MUL_B_W - LIMIT_W){1'b0}}, r_dt};
        end
    end

    sie_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_rsp   (mac_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_k       = r_k;
        n_render  = r_render;
        n_older   = r_older;
        n_newer   = r_newer;
        n_oc      = r_oc;
        n_frac    = r_frac;
        n_dt      = r_dt;
        n_ax      = r_ax;
        res_clear = 1'b0;
        div_start = 1'b0;
        rd_addr   = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_QUERY)) begin
                    n_render = render_ext[W-1:0];
                    n_k      = '0;
                    if (render_ext[W] || (r_fill == '0)) begin
                        n_oc      = OC_NONE;
                        res_clear = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                rd_addr = idx_dec(r_head);
                n_slot  = idx_dec(r_head);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                rd_addr = idx_dec(r_slot);
                if (hit) begin
                    n_older = rd_data;
                    n_ax    = '0;
                    if (r_k != '0) begin
                        n_oc      = OC_INTERP;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_oc    = OC_EXTRAP;
                        n_dt    = (elapsed > {{(W - LIMIT_W){1'b0}}, r_limit})
                                ? r_limit : elapsed[LIMIT_W-1:0];
                        n_state = S_MAC;
                    end
                end else if ((r_k + 1'b1) == r_fill) begin
                    n_oc      = OC_NONE;
                    res_clear = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_newer = rd_data;
                    n_slot  = idx_dec(r_slot);
                    n_k     = r_k + 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_frac  = div_quo;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (mac_req.vld) begin
                    n_ax = r_ax + 1'b1;
                end
                if (mac_rsp.vld && (mac_rsp.idx == AX_W'(NUM_AXES - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_ax    <= n_ax;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_render <= n_render;
        r_older  <= n_older;
        r_newer  <= n_newer;
        r_oc     <= n_oc;
        r_frac   <= n_frac;
        r_dt     <= n_dt;
        if (res_clear) begin
            r_res[0] <= '0;
            r_res[1] <= '0;
            r_res[2] <= '0;
        end else if (mac_rsp.vld) begin
            r_res[mac_rsp.idx] <= mac_rsp.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_oc <= r_oc;
            r_out_x  <= r_res[0];
            r_out_y  <= r_res[1];
            r_out_z  <= r_res[2];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_outcome   = r_out_oc;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;

endmodule

### hdl/sie_checker.sv
// port-level checks for the snapshot extrapolator, bound to the top level
// depends on sie_pkg and snapshot_interp_extrapolator_top_defines.svh
`include "snapshot_interp_extrapolator_top_defines.svh"

module sie_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_cmd,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_outcome,
    input logic signed [31:0] o_out_x,
    input logic signed [31:0] o_out_y,
    input logic signed [31:0] o_out_z
);
    import sie_pkg::*;

    logic        query_acc;
    logic        pos_zero;
    logic        oc_known;
    logic [97:0] out_bus;

    assign query_acc = i_in_valid && o_in_ready && (i_cmd == CMD_QUERY);
    assign pos_zero  = (o_out_x == 32'sd0) && (o_out_y == 32'sd0) && (o_out_z == 32'sd0);
    assign oc_known  = (o_outcome == OC_NONE) || (o_outcome == OC_INTERP)
                    || (o_outcome == OC_EXTRAP);
    assign out_bus   = {o_outcome, o_out_x, o_out_y, o_out_z};

    // a query transaction keeps the block busy for at least the next cycle
    `SIE_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, query_acc, !o_in_ready)

    // no match means an all-zero position
    `SIE_ASSERT_IMP(a_none_zero, i_clk, i_rst_n, o_out_valid && (o_outcome == OC_NONE), pos_zero)

    // only the three defined outcome codes are produced
    `SIE_ASSERT_IMP(a_outcome_code, i_clk, i_rst_n, o_out_valid, oc_known)

    // a stalled result holds
    `SIE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(out_bus))

endmodule

bind snapshot_interp_extrapolator_top sie_checker u_sie_checker (.*);

### bench/tb_top.sv
// self-checking bench for snapshot_interp_extrapolator_top: directed table, then random phases
// predicts untyped queries on its own snapshot ring; depends on sie_pkg and the rtl top level
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sie_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_LIMIT    = 4000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 140;
    localparam int DIR_ROWS      = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] snap_time;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] query_time;
    } t_cmd_item;

    typedef struct packed {
        t_outcome    oc;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_position;

    typedef struct packed {
        t_cmd_item item;
        logic      typed;
        t_position want;
    } t_row;

    localparam t_position NO_POS = '{OC_NONE, 32'd0, 32'd0, 32'd0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = 1'b0;
    logic [31:0]           i_snap_time = '0;
    logic signed [31:0]    i_pos_x = '0;
    logic signed [31:0]    i_pos_y = '0;
    logic signed [31:0]    i_pos_z = '0;
    logic signed [31:0]    i_vel_x = '0;
    logic signed [31:0]    i_vel_y = '0;
    logic signed [31:0]    i_vel_z = '0;
    logic [31:0]           i_query_time = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_outcome;
    logic signed [31:0]    o_out_x;
    logic signed [31:0]    o_out_y;
    logic signed [31:0]    o_out_z;

    snapshot_interp_extrapolator_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_snap_time  (i_snap_time),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_vel_z      (i_vel_z),
        .i_query_time (i_query_time),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_outcome    (o_outcome),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    t_snap              snap_ring [RING_DEPTH];
    int                 ring_head = 0;
    int                 ring_fill = 0;
    logic [DELAY_W-1:0] cur_delay = RENDER_DELAY_RESET;
    logic [LIMIT_W-1:0] cur_limit = EXTRAP_LIMIT_RESET;

    t_position pending_positions [$];
    int        n_fail = 0;
    int        idle_cycles = 0;
    bit        no_idle = 1'b0;
    logic [31:0] cur_t;

    t_row dir_rows [DIR_ROWS] = '{
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b1, '{OC_NONE, 32'h0, 32'h0, 32'h0}},
        '{'{CMD_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          1'b1, '{OC_NONE, 32'h0, 32'h0, 32'h0}},
        '{'{CMD_PUSH, 32'h3E8, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h80000000,
            32'h00010000, 32'hFFFFFFFF},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h21D82},
          1'b1, '{OC_EXTRAP, 32'h7FFFFFFF, 32'h80000000, 32'h00008000}},
        '{'{CMD_QUERY, 32'h5A5A5A5A, 32'h5A5A5A5A, 32'hA5A5A5A5, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h64},
          1'b1, '{OC_NONE, 32'h0, 32'h0, 32'h0}},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1D82},
          1'b1, '{OC_EXTRAP, 32'h7FFFFFFF, 32'h80000000, 32'h0}},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1D81},
          1'b1, '{OC_NONE, 32'h0, 32'h0, 32'h0}},
        '{'{CMD_PUSH, 32'hBB8, 32'hFFFF0000, 32'h00010000, 32'h40000000, 32'h0, 32'hFFFFFFFF,
            32'h80000000, 32'h0},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h216A},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h2551},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC192},
          1'b0, NO_POS},
        '{'{CMD_PUSH, 32'h1F4, 32'h12345678, 32'hEDCBA988, 32'h7FFFFFFF, 32'h00020000,
            32'hFFFE0000, 32'h7FFFFFFF, 32'hAAAAAAAA},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1BF2},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1B8D},
          1'b0, NO_POS},
        '{'{CMD_PUSH, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF,
            32'h80000000, 32'h55555555, 32'h0},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF},
          1'b0, NO_POS},
        '{'{CMD_PUSH, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h12345678},
          1'b0, NO_POS},
        '{'{CMD_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h199A},
          1'b1, '{OC_EXTRAP, 32'h0, 32'h0, 32'h0}}
    };

    function automatic logic [31:0] saturate32(input longint v);
        if (v > longint'(32'sh7FFFFFFF)) return 32'h7FFFFFFF;
        if (v < -longint'(64'sd2147483648)) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // newest-first search, then interpolate or coast along the velocity
    function automatic t_position render_position(input logic [31:0] qt);
        longint    render;
        longint    span;
        longint    delta;
        longint    frac;
        longint    dt;
        int        k;
        int        slot;
        bit        found;
        t_snap     a;
        t_snap     b;
        t_position r;
        r = NO_POS;
        found = 1'b0;
        slot = 0;
        render = longint'({32'd0, qt}) - longint'({47'd0, cur_delay});
        for (k = 0; k < ring_fill; k++) begin
            slot = (ring_head + 2 * RING_DEPTH - 1 - k) % RING_DEPTH;
            if (longint'({32'd0, snap_ring[slot].t}) <= render) begin
                found = 1'b1;
                break;
            end
        end
        if (!found) return r;
        a = snap_ring[slot];
        if (k > 0) begin
            b = snap_ring[(slot + 1) % RING_DEPTH];
            span = longint'({32'd0, b.t}) - longint'({32'd0, a.t});
            delta = render - longint'({32'd0, a.t});
            frac = 0;
            if (span > 0) begin
                frac = (delta * 65536) / span;
                if (frac > 65535) frac = 65535;
                if (frac < 0) frac = 0;
            end
            r.oc = OC_INTERP;
            r.x = saturate32(sx(a.px) + (((sx(b.px) - sx(a.px)) * frac) >>> 16));
            r.y = saturate32(sx(a.py) + (((sx(b.py) - sx(a.py)) * frac) >>> 16));
            r.z = saturate32(sx(a.pz) + (((sx(b.pz) - sx(a.pz)) * frac) >>> 16));
        end else begin
            dt = render - longint'({32'd0, a.t});
            if (dt > longint'({45'd0, cur_limit})) dt = longint'({45'd0, cur_limit});
            if (dt < 0) dt = 0;
            r.oc = OC_EXTRAP;
            r.x = saturate32(sx(a.px) + ((sx(a.vx) * dt) >>> 16));
            r.y = saturate32(sx(a.py) + ((sx(a.vy) * dt) >>> 16));
            r.z = saturate32(sx(a.pz) + ((sx(a.vz) * dt) >>> 16));
        end
        return r;
    endfunction

    function automatic logic [31:0] draw_coord();
        int mag;
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: begin
                mag = $urandom_range(0, 32'h00FFFFFF);
                return mag - 32'sh00800000;
            end
        endcase
    endfunction

    task automatic send_cmd(input t_cmd_item it, input logic typed, input t_position want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= it.cmd;
        i_snap_time  <= it.snap_time;
        i_pos_x      <= it.px;
        i_pos_y      <= it.py;
        i_pos_z      <= it.pz;
        i_vel_x      <= it.vx;
        i_vel_y      <= it.vy;
        i_vel_z      <= it.vz;
        i_query_time <= it.query_time;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.cmd == CMD_PUSH) begin
            snap_ring[ring_head] = '{it.snap_time, it.px, it.py, it.pz, it.vx, it.vy, it.vz};
            ring_head = (ring_head + 1) % RING_DEPTH;
            if (ring_fill < RING_DEPTH) ring_fill++;
        end else begin
            pending_positions.insert(pending_positions.size(),
                                     typed ? want : render_position(it.query_time));
        end
    endtask

    // caller lowers i_cfg_we after the last write
    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_RENDER_DELAY) cur_delay = data[DELAY_W-1:0];
        else if (idx == CFG_EXTRAP_LIMIT) cur_limit = data[LIMIT_W-1:0];
    endtask

    task automatic settle();
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_cmd_item           it;
        logic [31:0]         render;
        logic [CFG_DATA_W-1:0] delay_val;
        logic [CFG_DATA_W-1:0] limit_val;
        int                  pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_cmd(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            settle();
            case (ph)
                0: begin
                    delay_val = '0;
                    limit_val = '0;
                end
                1: begin
                    delay_val = 19'd65536;
                    limit_val = 19'd262144;
                end
                2: begin
                    delay_val = CFG_DATA_W'(RENDER_DELAY_RESET);
                    limit_val = CFG_DATA_W'(EXTRAP_LIMIT_RESET);
                end
                default: begin
                    delay_val = CFG_DATA_W'($urandom_range(0, 65536));
                    limit_val = CFG_DATA_W'($urandom_range(0, 262144));
                end
            endcase
            program_register(CFG_RENDER_DELAY, delay_val);
            program_register(CFG_EXTRAP_LIMIT, limit_val);
            // writes to unmapped indexes must leave both registers alone
            if (ph % 2 == 1)
                program_register((ph % 4 == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                 CFG_DATA_W'($urandom));
            i_cfg_we <= 1'b0;
            no_idle = (ph % 3 == 2);
            cur_t = (ph % 2 == 1) ? $urandom : $urandom_range(0, 2000);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it.cmd        = CMD_QUERY;
                it.snap_time  = $urandom;
                it.px         = $urandom;
                it.py         = $urandom;
                it.pz         = $urandom;
                it.vx         = $urandom;
                it.vy         = $urandom;
                it.vz         = $urandom;
                it.query_time = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    it.cmd = CMD_PUSH;
                    // a few out-of-order snapshot times
                    if (pick >= 3) begin
                        cur_t = cur_t + $urandom_range(1, 24000);
                        it.snap_time = cur_t;
                    end
                    it.px = draw_coord();
                    it.py = draw_coord();
                    it.pz = draw_coord();
                    it.vx = draw_coord();
                    it.vy = draw_coord();
                    it.vz = draw_coord();
                end else if (pick < 95) begin
                    case ($urandom_range(0, 3))
                        0: render = cur_t + $urandom_range(0, 2 * int'(cur_limit) + 10);
                        1: render = cur_t - $urandom_range(0, 100000);
                        2: render = cur_t - $urandom_range(0, 500000);
                        default: render = $urandom;
                    endcase
                    it.query_time = render + 32'(cur_delay);
                end else begin
                    it.cmd = 1'($urandom_range(0, 1));
                end
                send_cmd(it, 1'b0, NO_POS);
            end
        end

        i_in_valid <= 1'b0;
        settle();
        if (n_fail == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        int        stall;
        t_position want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (pending_positions.size() == 0) begin
                $error("unexpected result transaction: outcome %0d", o_outcome);
                n_fail++;
            end else begin
                want = pending_positions.pop_front();
                if (o_outcome !== want.oc) begin
                    $error("outcome: expected %0d, actual %0d", want.oc, o_outcome);
                    n_fail++;
                end
                if (o_out_x !== want.x) begin
                    $error("out_x: expected %0d, actual %0d", $signed(want.x), o_out_x);
                    n_fail++;
                end
                if (o_out_y !== want.y) begin
                    $error("out_y: expected %0d, actual %0d", $signed(want.y), o_out_y);
                    n_fail++;
                end
                if (o_out_z !== want.z) begin
                    $error("out_z: expected %0d, actual %0d", $signed(want.z), o_out_z);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
